// File: rtl/core/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and codes of the context slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  localparam int unsigned SlotsDefault = 64;
  localparam int unsigned IdBitsDefault = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CountW = 7;
  localparam logic [CountW-1:0] CreditMax = 7'd127;
  localparam logic [CountW-1:0] CapacityReset = 7'd64;

  localparam logic [2:0] OP_REGISTER   = 3'd0;
  localparam logic [2:0] OP_UNREGISTER = 3'd1;
  localparam logic [2:0] OP_FIND       = 3'd2;
  localparam logic [2:0] OP_RESERVE    = 3'd3;
  localparam logic [2:0] OP_RELEASE    = 3'd4;
  localparam logic [2:0] OP_CHECK      = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_NOSLOT   = 2'd3;

  localparam logic [2:0] SEL_CREATED    = 3'd0;
  localparam logic [2:0] SEL_DESTROYED  = 3'd1;
  localparam logic [2:0] SEL_REQUESTS   = 3'd2;
  localparam logic [2:0] SEL_REJECTIONS = 3'd3;
  localparam logic [2:0] SEL_REUSES     = 3'd4;
  localparam logic [2:0] SEL_PEAK       = 3'd5;
  localparam logic [2:0] SEL_TOTAL      = 3'd6;

  localparam logic [CfgIdxW-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REUSE    = 2'd1;

  typedef struct packed {
    logic [2:0]         operation;
    logic [31:0]        ctx_id;
    logic signed [15:0] attr_a;
    logic signed [15:0] attr_b;
    logic signed [15:0] attr_c;
    logic [6:0]         count;
    logic [2:0]         stat_select;
  } cst_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         slot_index;
    logic signed [15:0] found_sphere;
    logic signed [15:0] found_level;
    logic signed [15:0] found_group;
    logic [6:0]         active_now;
    logic [6:0]         available_now;
    logic [6:0]         reuse_credit_now;
    logic [31:0]        stat_value;
  } cst_rsp_t;

  typedef struct packed {
    logic       reg_ok;
    logic       unreg_ok;
    logic       reserve;
    logic       release_op;
    logic [6:0] count;
  } cst_upd_t;

  typedef struct packed {
    logic [6:0]  active;
    logic [6:0]  avail;
    logic [6:0]  credit;
    logic [31:0] stat;
  } cst_view_t;

endpackage

`default_nettype wire

// File: rtl/core/cst_mem.sv
// ----------------------------------------------------------------------------
// cst_mem
// Single-port-write, single-port-read slot memory, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 81
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cst_stats.sv
// ----------------------------------------------------------------------------
// cst_stats
// Active count, reuse credit, peak and event counters with post-update view.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_stats
  import cst_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      apply_i,
  input  wire cst_upd_t  upd_i,
  input  wire logic [6:0] cap_i,
  input  wire logic      reuse_en_i,
  input  wire logic [6:0] count_i,
  input  wire logic [2:0] stat_sel_i,
  output logic [6:0]     active_o,
  output logic           reserve_rej_o,
  output logic           check_fail_o,
  output cst_view_t      view_o
);

  logic [6:0]  active_q, active_d, credit_q, credit_d, peak_q, peak_d;
  logic [31:0] created_q, created_d, destroyed_q, destroyed_d;
  logic [31:0] requests_q, requests_d, rejects_q, rejects_d;
  logic [31:0] reuses_q, reuses_d, total_q, total_d;
  logic [6:0]  avail_cur;

  assign active_o = active_q;
  assign reserve_rej_o = ({1'b0, active_q} + {1'b0, count_i}) > {1'b0, cap_i};
  assign avail_cur = (active_q < cap_i) ? cap_i - active_q : 7'd0;
  assign check_fail_o = avail_cur < count_i;

  always_comb begin
    active_d    = active_q;
    credit_d    = credit_q;
    peak_d      = peak_q;
    created_d   = created_q;
    destroyed_d = destroyed_q;
    requests_d  = requests_q;
    rejects_d   = rejects_q;
    reuses_d    = reuses_q;
    total_d     = total_q;
    if (upd_i.reg_ok) begin
      if (reuse_en_i && credit_q != 7'd0) begin
        credit_d = credit_q - 7'd1;
        reuses_d = reuses_q + 32'd1;
      end
      active_d  = active_q + 7'd1;
      created_d = created_q + 32'd1;
      total_d   = total_q + 32'd1;
      if (active_d > peak_q) begin
        peak_d = active_d;
      end
    end
    if (upd_i.unreg_ok) begin
      if (active_q != 7'd0) begin
        active_d = active_q - 7'd1;
      end
      destroyed_d = destroyed_q + 32'd1;
      if (reuse_en_i && credit_q < CreditMax) begin
        credit_d = credit_q + 7'd1;
      end
    end
    if (upd_i.reserve) begin
      requests_d = requests_q + 32'd1;
      if (reserve_rej_o) begin
        rejects_d = rejects_q + 32'd1;
      end else begin
        active_d = active_q + upd_i.count;
      end
    end
    if (upd_i.release_op) begin
      active_d = (active_q > upd_i.count) ? active_q - upd_i.count : 7'd0;
    end
  end

  always_comb begin
    view_o.active = active_d;
    view_o.avail  = (active_d < cap_i) ? cap_i - active_d : 7'd0;
    view_o.credit = credit_d;
    case (stat_sel_i)
      SEL_CREATED:    view_o.stat = created_d;
      SEL_DESTROYED:  view_o.stat = destroyed_d;
      SEL_REQUESTS:   view_o.stat = requests_d;
      SEL_REJECTIONS: view_o.stat = rejects_d;
      SEL_REUSES:     view_o.stat = reuses_d;
      SEL_PEAK:       view_o.stat = {25'd0, peak_d};
      SEL_TOTAL:      view_o.stat = total_d;
      default:        view_o.stat = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      credit_q    <= '0;
      peak_q      <= '0;
      created_q   <= '0;
      destroyed_q <= '0;
      requests_q  <= '0;
      rejects_q   <= '0;
      reuses_q    <= '0;
      total_q     <= '0;
    end else if (apply_i) begin
      active_q    <= active_d;
      credit_q    <= credit_d;
      peak_q      <= peak_d;
      created_q   <= created_d;
      destroyed_q <= destroyed_d;
      requests_q  <= requests_d;
      rejects_q   <= rejects_d;
      reuses_q    <= reuses_d;
      total_q     <= total_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/context_slot_table_with_admission.sv
// ----------------------------------------------------------------------------
// context_slot_table_with_admission
// Slot table of thread contexts with admission control and statistics.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel, one transaction each; every request
// yields exactly one response transaction on the out channel. Configuration
// writes (capacity, reuse enable) use a separate channel that is always ready
// and must only be issued while the block is idle.
// Reserve, release, check and unknown operations go from accept to S_FIN and are
// answered from there. Register, unregister and find walk the slot memory, one
// entry per cycle through its single read port with registered read data, up to
// capacity entries or until the first match; a register on a full table skips it.
// After reset the block clears the valid bits of all SLOTS entries of the slot
// memory, one entry a cycle; in_ready_o stays low during that pass.
// A new request is accepted while a response waits; the block then holds the
// finished result and stalls until the receiver takes the pending response.
// ----------------------------------------------------------------------------
`default_nettype none

module context_slot_table_with_admission
  import cst_pkg::*;
#(
  parameter int unsigned SLOTS   = SlotsDefault,
  parameter int unsigned ID_BITS = IdBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cst_req_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output cst_rsp_t                out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [6:0]         cfg_data_i
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned MW = 1 + ID_BITS + 48;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_FIN} state_e;

  state_e          state_q;
  cst_req_t        req_q;
  logic [1:0]      status_q;
  logic [IW-1:0]   slot_q, addr_q, chk_idx_q, last_idx;
  logic            hit_q, chk_q, issue_done_q;
  logic [47:0]     found_q;
  logic [6:0]      capacity_q, cap;
  logic            reuse_q;
  logic            out_valid_q;
  cst_rsp_t        out_q;

  logic [ID_BITS+31:0] id_ext;
  logic [ID_BITS-1:0]  req_id;
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr;
  logic [MW-1:0]       mem_wdata, mem_rdata;
  logic                r_valid, match, fire;
  logic [ID_BITS-1:0]  r_owner;
  logic [1:0]          fin_status;
  logic [6:0]          active;
  logic                reserve_rej, check_fail;
  cst_upd_t            upd;
  cst_view_t           view;
  logic [5:0]          slot_out;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (capacity_q == 7'd0) begin
      cap = 7'd1;
    end else if (int'(capacity_q) > SLOTS) begin
      cap = 7'(SLOTS);
    end else begin
      cap = capacity_q;
    end
  end
  assign last_idx = IW'(cap - 7'd1);

  assign id_ext = {{ID_BITS{1'b0}}, req_q.ctx_id};
  assign req_id = id_ext[ID_BITS-1:0];

  assign r_valid = mem_rdata[MW-1];
  assign r_owner = mem_rdata[MW-2:48];
  assign match   = (req_q.operation == OP_REGISTER) ? !r_valid
                                                    : (r_valid && r_owner == req_id);
  assign fire    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  assign mem_re = (state_q == S_SCAN) && !issue_done_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = '0;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = addr_q;
    end else if (fire && hit_q) begin
      if (req_q.operation == OP_REGISTER) begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, req_id, req_q.attr_a, req_q.attr_b, req_q.attr_c};
      end else if (req_q.operation == OP_UNREGISTER) begin
        mem_we = 1'b1;
      end
    end
  end

  cst_mem #(
    .Depth (SLOTS),
    .Width (MW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    upd.reg_ok     = fire && hit_q && req_q.operation == OP_REGISTER;
    upd.unreg_ok   = fire && hit_q && req_q.operation == OP_UNREGISTER;
    upd.reserve    = fire && req_q.operation == OP_RESERVE;
    upd.release_op = fire && req_q.operation == OP_RELEASE;
    upd.count      = req_q.count;
  end

  cst_stats u_stats (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .apply_i       (fire),
    .upd_i         (upd),
    .cap_i         (cap),
    .reuse_en_i    (reuse_q),
    .count_i       (req_q.count),
    .stat_sel_i    (req_q.stat_select),
    .active_o      (active),
    .reserve_rej_o (reserve_rej),
    .check_fail_o  (check_fail),
    .view_o        (view)
  );

  always_comb begin
    case (req_q.operation)
      OP_REGISTER, OP_UNREGISTER, OP_FIND: fin_status = status_q;
      OP_RESERVE: fin_status = reserve_rej ? ST_FULL : ST_OK;
      OP_CHECK:   fin_status = check_fail ? ST_FULL : ST_OK;
      default:    fin_status = ST_OK;
    endcase
  end

  assign slot_out = hit_q ? 6'({{6{1'b0}}, slot_q}) : 6'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
      reuse_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CAPACITY: capacity_q <= cfg_data_i;
        CFG_REUSE:    reuse_q    <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      addr_q       <= '0;
      chk_q        <= 1'b0;
      issue_done_q <= 1'b0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (addr_q == IW'(SLOTS - 1)) begin
            state_q <= S_IDLE;
          end else begin
            addr_q <= addr_q + IW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            req_q        <= in_data_i;
            hit_q        <= 1'b0;
            addr_q       <= '0;
            chk_q        <= 1'b0;
            issue_done_q <= 1'b0;
            status_q     <= ST_OK;
            state_q      <= S_FIN;
            if (in_data_i.operation == OP_REGISTER && active >= cap) begin
              status_q <= ST_FULL;
            end else if (in_data_i.operation == OP_REGISTER ||
                         in_data_i.operation == OP_UNREGISTER ||
                         in_data_i.operation == OP_FIND) begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!issue_done_q) begin
            chk_q     <= 1'b1;
            chk_idx_q <= addr_q;
            if (addr_q == last_idx) begin
              issue_done_q <= 1'b1;
            end else begin
              addr_q <= addr_q + IW'(1);
            end
          end
          if (chk_q) begin
            if (match) begin
              hit_q    <= 1'b1;
              slot_q   <= chk_idx_q;
              found_q  <= mem_rdata[47:0];
              status_q <= ST_OK;
              state_q  <= S_FIN;
            end else if (chk_idx_q == last_idx) begin
              status_q <= (req_q.operation == OP_REGISTER) ? ST_NOSLOT : ST_NOTFOUND;
              state_q  <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (fire) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.status           <= fin_status;
      out_q.slot_index       <= slot_out;
      out_q.found_sphere     <= '0;
      out_q.found_level      <= '0;
      out_q.found_group      <= '0;
      if (hit_q && req_q.operation == OP_FIND) begin
        out_q.found_sphere <= found_q[47:32];
        out_q.found_level  <= found_q[31:16];
        out_q.found_group  <= found_q[15:0];
      end
      out_q.active_now       <= view.active;
      out_q.available_now    <= view.avail;
      out_q.reuse_credit_now <= view.credit;
      out_q.stat_value       <= view.stat;
    end
  end

  a_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_FIN || state_q == S_CLEAR))
    else $error("slot memory written outside clear or finish");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && chk_q) |-> (chk_idx_q <= last_idx))
    else $error("scan ran past capacity");

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SCAN || state_q == S_FIN))
    else $error("accepted transaction not taken up");

  a_hit_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && hit_q) |-> (req_q.operation == OP_REGISTER ||
      req_q.operation == OP_UNREGISTER || req_q.operation == OP_FIND))
    else $error("slot hit on an operation without a scan");

endmodule

`default_nettype wire
